@@ hdl/bsp_pkg.sv @@
`timescale 1ns / 1ps

package bsp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] chunk_kind;
    logic       chunk_end;
    logic       text_end;
  } out_t;

  // chunk classes; run kind zero also means chunk start
  localparam logic [2:0] KIND_CONTR  = 3'd0;
  localparam logic [2:0] KIND_LETTER = 3'd1;
  localparam logic [2:0] KIND_DIGIT  = 3'd2;
  localparam logic [2:0] KIND_SPACE  = 3'd3;
  localparam logic [2:0] KIND_OTHER  = 3'd4;

  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_E     = 8'h65;

  localparam logic [7:0] HIGH_BYTE = 8'h80;
  localparam logic [7:0] MASK_2B   = 8'hE0;
  localparam logic [7:0] LEAD_2B   = 8'hC0;
  localparam logic [7:0] MASK_3B   = 8'hF0;
  localparam logic [7:0] LEAD_3B   = 8'hE0;
  localparam logic [7:0] MASK_4B   = 8'hF8;
  localparam logic [7:0] LEAD_4B   = 8'hF0;

  localparam int MAX_RES  = 3;
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      held;
  } win_t;

  typedef struct packed {
    logic [2:0] run_kind;
    logic [1:0] cont_left;
    logic [1:0] contr_left;
  } run_state_t;

  function automatic logic [2:0] class_of(input logic [7:0] b);
    logic [2:0] k;
    if (b inside {[8'h61:8'h7A], [8'h41:8'h5A]} || b >= HIGH_BYTE) k = KIND_LETTER;
    else if (b inside {[8'h30:8'h39]}) k = KIND_DIGIT;
    else if (b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) k = KIND_SPACE;
    else k = KIND_OTHER;
    return k;
  endfunction

  function automatic logic [1:0] follow_count(input logic [7:0] b);
    logic [1:0] n;
    if ((b & MASK_2B) == LEAD_2B) n = 2'd1;
    else if ((b & MASK_3B) == LEAD_3B) n = 2'd2;
    else if ((b & MASK_4B) == LEAD_4B) n = 2'd3;
    else n = 2'd0;
    return n;
  endfunction

endpackage

@@ hdl/bsp_step.sv @@
`timescale 1ns / 1ps

module bsp_step (
  input  bsp_pkg::win_t       win_in,
  input  bsp_pkg::run_state_t st_in,
  input  logic                en,
  input  logic                ended,
  output bsp_pkg::win_t       win_out,
  output bsp_pkg::run_state_t st_out,
  output logic                emit,
  output bsp_pkg::out_t       res
);
  import bsp_pkg::*;

  logic [7:0] h;
  logic [7:0] nx;
  logic [7:0] tb;
  logic [2:0] nx_kind;
  logic       has_next;
  logic       last;
  logic       member;
  logic       decided;
  logic       more;
  logic [2:0] rk_eff;
  logic [1:0] left;
  logic [1:0] qm;
  logic       qwait;

  always_comb begin
    h        = win_in.bytes[0];
    nx       = win_in.bytes[1];
    tb       = win_in.bytes[2];
    nx_kind  = class_of(nx);
    has_next = win_in.held > 2'd1;
    last     = ended && (win_in.held == 2'd1);
    win_out  = win_in;
    st_out   = st_in;
    emit     = 1'b0;
    res      = '0;
    member   = 1'b0;
    decided  = 1'b0;
    more     = 1'b0;
    rk_eff   = KIND_CONTR;
    left     = 2'd0;
    qm       = 2'd0;
    qwait    = 1'b0;

    // contraction match on the window
    if (!has_next) begin
      qwait = !ended;
    end else if (nx == CH_S || nx == CH_T || nx == CH_M || nx == CH_D) begin
      qm = 2'd2;
    end else if (nx == CH_R || nx == CH_V || nx == CH_L) begin
      if (win_in.held < 2'd3) begin
        qwait = !ended;
      end else if (((nx == CH_R || nx == CH_V) && tb == CH_E) || (nx == CH_L && tb == CH_L)) begin
        qm = 2'd3;
      end
    end

    if (en && win_in.held != 2'd0) begin
      if (st_in.contr_left != 2'd0) begin
        emit              = 1'b1;
        res.out_byte      = h;
        res.chunk_kind    = KIND_CONTR;
        res.chunk_end     = (st_in.contr_left == 2'd1);
        res.text_end      = last;
        st_out.contr_left = st_in.contr_left - 2'd1;
      end else if (st_in.run_kind != KIND_CONTR) begin
        rk_eff = st_in.run_kind;
        member = 1'b1;
      end else if (h == CH_QUOTE) begin
        if (!qwait) begin
          if (qm != 2'd0) begin
            emit              = 1'b1;
            res.out_byte      = h;
            res.chunk_kind    = KIND_CONTR;
            res.chunk_end     = 1'b0;
            res.text_end      = last;
            st_out.contr_left = qm - 2'd1;
          end else begin
            rk_eff = KIND_OTHER;
            member = 1'b1;
          end
        end
      end else if (h == CH_SPACE) begin
        if (!has_next) begin
          if (ended) begin
            rk_eff = KIND_SPACE;
            member = 1'b1;
          end
        end else if (nx_kind != KIND_SPACE) begin
          emit            = 1'b1;
          res.out_byte    = h;
          res.chunk_kind  = nx_kind;
          res.chunk_end   = 1'b0;
          res.text_end    = 1'b0;
          st_out.run_kind = nx_kind;
        end else begin
          rk_eff = KIND_SPACE;
          member = 1'b1;
        end
      end else begin
        rk_eff = class_of(h);
        member = 1'b1;
      end

      if (member) begin
        st_out.run_kind = rk_eff;
        left = st_in.cont_left;
        if (rk_eff == KIND_LETTER) begin
          left = (st_in.cont_left != 2'd0) ? st_in.cont_left - 2'd1 : follow_count(h);
        end
        if (last) begin
          more    = 1'b0;
          decided = 1'b1;
        end else if (rk_eff == KIND_LETTER && left != 2'd0) begin
          more    = 1'b1;
          decided = 1'b1;
        end else if (has_next) begin
          more    = (nx_kind == rk_eff);
          decided = 1'b1;
        end
        if (decided) begin
          emit             = 1'b1;
          res.out_byte     = h;
          res.chunk_kind   = rk_eff;
          res.chunk_end    = !more;
          res.text_end     = last;
          st_out.cont_left = more ? left : 2'd0;
          st_out.run_kind  = more ? rk_eff : KIND_CONTR;
        end
      end

      if (emit) begin
        win_out.bytes = {8'h00, win_in.bytes[2], win_in.bytes[1]};
        win_out.held  = win_in.held - 2'd1;
      end
    end
  end

endmodule

@@ hdl/bsp_outq.sv @@
`timescale 1ns / 1ps

module bsp_outq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [bsp_pkg::MAX_RES-1:0] push,
  input  bsp_pkg::out_t             items [bsp_pkg::MAX_RES],
  output logic                      room,
  output logic                      q_valid,
  output bsp_pkg::out_t             q_data,
  input  logic                      q_stall
);
  import bsp_pkg::*;

  out_t             mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_CW-1:0] cnt;
  logic [OQ_CW-1:0] n_push;
  logic             pop;

  assign n_push  = OQ_CW'($countones(push));
  assign q_valid = (cnt != '0);
  assign q_data  = mem[rd_ptr];
  assign pop     = q_valid && !q_stall;
  assign room    = (cnt <= OQ_CW'(OQ_DEPTH - MAX_RES));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_AW'(n_push);
      rd_ptr <= rd_ptr + OQ_AW'(pop);
      cnt    <= cnt + n_push - OQ_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (push[i]) begin
        mem[wr_ptr + OQ_AW'(i)] <= items[i];
      end
    end
  end

endmodule

@@ hdl/byte_stream_pretokenizer_core.sv @@
`timescale 1ns / 1ps

// Byte-level pretokenizer: tags each text byte with its chunk class and marks chunk ends.
// Input channel item / item_valid / item_stall carries one byte and a last-of-text flag;
// a transaction completes when item_valid is high and item_stall is low.
// Output channel result / result_valid / result_stall carries one tagged byte per
// transaction, in text order.
// A byte whose chunk is settled by the bytes already seen passes through the input register
// and the output queue before it is offered; a byte may also wait for up to two following
// bytes of lookahead.
// The last byte of a text flushes everything held and returns to a chunk start.
// Throughput: one input byte per cycle while the queue has room. An input register feeds
// three chained release stages, each of which can emit one byte, into an eight-entry
// output queue; an input is processed only when the queue has room for three entries.
// When the receiver stalls, the queue fills and item_stall rises once fewer than three
// entries are free while a byte is held in the input register.
// Reset clears the lookahead, the run state and the queue; nothing is emitted until new
// input arrives.

module byte_stream_pretokenizer_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  bsp_pkg::in_t   item,
  output logic           result_valid,
  input  logic           result_stall,
  output bsp_pkg::out_t  result
);
  import bsp_pkg::*;

  in_t        item_r;
  logic       item_full;
  logic       room;
  logic       process;
  win_t       win;
  run_state_t st;
  win_t       win_add;

  win_t       wins [MAX_RES+1];
  run_state_t sts  [MAX_RES+1];
  logic [MAX_RES-1:0] emit;
  logic [MAX_RES-1:0] stage_en;
  out_t       res  [MAX_RES];
  logic [1:0] n_emit;

  assign process    = item_full && room;
  assign item_stall = item_full && !room;
  assign n_emit     = 2'($countones(emit));

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_full <= 1'b1;
    end else if (process) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_r <= item;
    end
  end

  always_comb begin
    win_add                 = win;
    win_add.bytes[win.held] = item_r.data_byte;
    win_add.held            = win.held + 2'd1;
  end

  assign wins[0] = win_add;
  assign sts[0]  = st;

  for (genvar i = 0; i < MAX_RES; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign stage_en[i] = process;
    end else begin : g_next
      assign stage_en[i] = emit[i-1];
    end
    bsp_step u_step (
      .win_in  (wins[i]),
      .st_in   (sts[i]),
      .en      (stage_en[i]),
      .ended   (item_r.last_byte),
      .win_out (wins[i+1]),
      .st_out  (sts[i+1]),
      .emit    (emit[i]),
      .res     (res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      st  <= '0;
    end else if (process) begin
      if (item_r.last_byte) begin
        win <= '0;
        st  <= '0;
      end else begin
        win <= wins[MAX_RES];
        st  <= sts[MAX_RES];
      end
    end
  end

  bsp_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (emit),
    .items   (res),
    .room    (room),
    .q_valid (result_valid),
    .q_data  (result),
    .q_stall (result_stall)
  );

  a_flush_on_last: assert property (@(posedge clk) disable iff (rst)
    process && item_r.last_byte |=> win.held == 2'd0 && st == '0)
    else $error("state not cleared after last byte");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    process && !item_r.last_byte |=> win.held != 2'd3)
    else $error("lookahead overflow");

  a_byte_count: assert property (@(posedge clk) disable iff (rst)
    process && !item_r.last_byte |=>
      win.held == 2'($past(win.held) + 2'd1 - $past(n_emit)))
    else $error("lookahead byte count mismatch");

  a_contr_at_start: assert property (@(posedge clk) disable iff (rst)
    st.contr_left != 2'd0 |-> st.run_kind == KIND_CONTR)
    else $error("contraction pending inside an open run");

endmodule
